/* hdl/sis_pkg.sv */
// Shared codes, result type and helper function of the sorted integer set.
`timescale 1ns / 1ps
`default_nettype none
package sis_pkg;

	// request kinds
	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_FIND   = 2'd2;
	localparam logic [1:0] REQ_GET    = 2'd3;

	// result status
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// storage width classes
	localparam logic [1:0] CLS_8  = 2'd0;
	localparam logic [1:0] CLS_16 = 2'd1;
	localparam logic [1:0] CLS_32 = 2'd2;
	localparam logic [1:0] CLS_64 = 2'd3;

	localparam int unsigned DATA_W = 64;

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] read_value;
		logic [1:0]        width_class;
	} sis_res_t;

	// smallest class whose signed range holds v: the bits above the sign bit
	// of the class must all match it
	function automatic logic [1:0] class_of(input logic [DATA_W-1:0] v);
		logic [1:0] c;
		if ((&v[63:7]) || !(|v[63:7]))
			c = CLS_8;
		else if ((&v[63:15]) || !(|v[63:15]))
			c = CLS_16;
		else if ((&v[63:31]) || !(|v[63:31]))
			c = CLS_32;
		else
			c = CLS_64;
		return c;
	endfunction

endpackage
`default_nettype wire

/* hdl/sis_req_if.sv */
// Request channel: valid/ready handshake with request kind, value and index.
`timescale 1ns / 1ps
`default_nettype none
interface sis_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [63:0] value;
	logic [7:0]         index;

	modport source (output valid, req_type, value, index, input ready);
	modport sink   (input valid, req_type, value, index, output ready);
endinterface
`default_nettype wire

/* hdl/sis_rsp_if.sv */
// Result channel: valid/ready handshake with status, read value, set size, width class and packed byte length.
`timescale 1ns / 1ps
`default_nettype none
interface sis_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [63:0] read_value;
	logic [8:0]         entry_count;
	logic [1:0]         width_class;
	logic [11:0]        packed_bytes;

	modport source (output valid, status, read_value, entry_count, width_class,
		packed_bytes, input ready);
	modport sink   (input valid, status, read_value, entry_count, width_class,
		packed_bytes, output ready);
endinterface
`default_nettype wire

/* hdl/sis_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps
`default_nettype none
module sis_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hdl/sis_seq.sv */
// Sequencer: binary search, shift up/down and get over the entry RAM.
`timescale 1ns / 1ps
`default_nettype none
module sis_seq
	import sis_pkg::*;
#(
	parameter int unsigned CAPACITY = 256,
	localparam int unsigned AW = $clog2(CAPACITY),
	localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	sis_req_if.sink                req,
	// entry RAM
	output logic                   ram_we,
	output logic [AW-1:0]          ram_waddr,
	output logic [DATA_W-1:0]      ram_wdata,
	output logic                   ram_re,
	output logic [AW-1:0]          ram_raddr,
	input  wire logic [DATA_W-1:0] ram_rdata,
	// result handoff
	input  wire logic              res_free,
	output logic                   res_valid,
	output sis_res_t               res,
	output logic [CW-1:0]          res_count
);
	localparam int unsigned IW = (CW > 8) ? CW : 8;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SRCH   = 3'd1;
	localparam logic [2:0] S_PROBE  = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_UP     = 3'd4;
	localparam logic [2:0] S_DOWN   = 3'd5;
	localparam logic [2:0] S_GET    = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	logic [2:0]        state_q;
	logic [1:0]        req_q;
	logic [DATA_W-1:0] val_q;
	logic [CW-1:0]     lo_q, hi_q, mid_q, left_q, count_q;
	logic              hit_q;
	logic [AW-1:0]     r_q, dst_s1;
	logic              pend_s1;
	logic [1:0]        class_q, status_q;
	logic [DATA_W-1:0] rd_q;

	logic [CW-1:0] mid;
	logic [IW-1:0] idx_w, cnt_w;
	logic          get_in_range;
	logic [1:0]    new_class;

	assign mid          = lo_q + ((hi_q - lo_q) >> 1);
	assign idx_w        = IW'(req.index);
	assign cnt_w        = IW'(count_q);
	assign get_in_range = idx_w < cnt_w;
	assign new_class    = class_of(val_q);

	assign res.status      = status_q;
	assign res.read_value  = rd_q;
	assign res.width_class = class_q;
	assign res_count       = count_q;

	always_comb begin
		req.ready = (state_q == S_IDLE);
		ram_re    = 1'b0;
		ram_raddr = '0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = val_q;
		res_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid && req.req_type == REQ_GET && get_in_range) begin
					ram_re    = 1'b1;
					ram_raddr = idx_w[AW-1:0];
				end
			end
			S_SRCH: begin
				if (lo_q < hi_q) begin
					ram_re    = 1'b1;
					ram_raddr = mid[AW-1:0];
				end
			end
			S_UP: begin
				if (pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = dst_s1;
					ram_wdata = ram_rdata;
				end else if (left_q == '0) begin
					// all higher entries moved: drop the new value in
					ram_we    = 1'b1;
					ram_waddr = lo_q[AW-1:0];
				end
				if (left_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = r_q;
				end
			end
			S_DOWN: begin
				if (pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = dst_s1;
					ram_wdata = ram_rdata;
				end
				if (left_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = r_q;
				end
			end
			S_FIN: res_valid = res_free;
			S_PROBE, S_DECIDE, S_GET: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			class_q <= CLS_8;
			pend_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_q    <= req.req_type;
						val_q    <= req.value;
						lo_q     <= '0;
						hi_q     <= count_q;
						hit_q    <= 1'b0;
						rd_q     <= '0;
						status_q <= ST_OK;
						pend_s1  <= 1'b0;
						if (req.req_type == REQ_GET) begin
							if (get_in_range) begin
								state_q <= S_GET;
							end else begin
								status_q <= ST_MISS;
								rd_q     <= '1;
								state_q  <= S_FIN;
							end
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= S_PROBE;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_PROBE: begin
					if ($signed(ram_rdata) < $signed(val_q))
						lo_q <= mid_q + CW'(1);
					else
						hi_q <= mid_q;
					// distinct entries: a present value is always probed
					if (ram_rdata == val_q)
						hit_q <= 1'b1;
					state_q <= S_SRCH;
				end
				S_DECIDE: begin
					priority if (req_q == REQ_FIND) begin
						status_q <= hit_q ? ST_OK : ST_MISS;
						state_q  <= S_FIN;
					end else if (req_q == REQ_ADD && hit_q) begin
						status_q <= ST_MISS;
						state_q  <= S_FIN;
					end else if (req_q == REQ_ADD && count_q >= CW'(CAPACITY)) begin
						status_q <= ST_FULL;
						state_q  <= S_FIN;
					end else if (req_q == REQ_ADD) begin
						left_q  <= count_q - lo_q;
						r_q     <= AW'(count_q - CW'(1));
						state_q <= S_UP;
					end else if (req_q == REQ_REMOVE && !hit_q) begin
						status_q <= ST_MISS;
						state_q  <= S_FIN;
					end else if (req_q == REQ_REMOVE) begin
						left_q  <= count_q - lo_q - CW'(1);
						r_q     <= AW'(lo_q + CW'(1));
						state_q <= S_DOWN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_UP: begin
					if (left_q != '0) begin
						pend_s1 <= 1'b1;
						dst_s1  <= r_q + AW'(1);
						r_q     <= r_q - AW'(1);
						left_q  <= left_q - CW'(1);
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							count_q <= count_q + CW'(1);
							if (new_class > class_q)
								class_q <= new_class;
							state_q <= S_FIN;
						end
					end
				end
				S_DOWN: begin
					if (left_q != '0) begin
						pend_s1 <= 1'b1;
						dst_s1  <= r_q - AW'(1);
						r_q     <= r_q + AW'(1);
						left_q  <= left_q - CW'(1);
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							count_q <= count_q - CW'(1);
							state_q <= S_FIN;
						end
					end
				end
				S_GET: begin
					rd_q    <= ram_rdata;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_free)
						state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

/* hdl/sorted_integer_set_core.sv */
// Top level of the sorted integer set: entry RAM, sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
// Sorted set of distinct signed 64-bit integers, up to CAPACITY entries, kept
// in ascending order in one simple dual-port RAM (one write, one registered
// read per cycle). Requests: add, remove, find, get by index. One request is
// worked at a time; a new one is taken as soon as the sequencer is idle, even
// while the previous result still waits on the result channel. Each request
// but get runs a binary search of up to L = ceil(log2(n+1)) probes, with n
// the entry count; an add or remove then moves the k entries above the insert
// or delete position, streaming one entry per cycle through the RAM's read
// and write ports, makes any last write of the shift and finishes; an add
// writes the new value into the freed position as it finishes. The worst
// case is a remove at the head of a full set.
// The width class only grows, on a successful add; every result carries the
// count, the class and count << class as packed byte length. The RAM needs no
// clearing: only positions below the count are ever read.
module sorted_integer_set_core
	import sis_pkg::*;
#(
	parameter int unsigned CAPACITY = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sis_req_if.sink   req,
	sis_rsp_if.source rsp
);
	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;

	logic          res_free, res_valid;
	sis_res_t      res;
	logic [CW-1:0] res_count;

	logic vld_q;

	sis_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sis_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res       (res),
		.res_count (res_count)
	);

	// result register: free when empty or its transfer completes this cycle
	assign res_free  = !vld_q || rsp.ready;
	assign rsp.valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (res_valid)
			vld_q <= 1'b1;
		else if (rsp.ready)
			vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp.status       <= res.status;
			rsp.read_value   <= res.read_value;
			rsp.entry_count  <= 9'(res_count);
			rsp.width_class  <= res.width_class;
			// low bits of the product depend only on low bits of the count
			rsp.packed_bytes <= 12'(res_count) << res.width_class;
		end
	end
endmodule
`default_nettype wire
